// ----- hw/rtl/block_decomposed_range_sum_core_defines.svh -----
// Assertion macros used by the range sum core sequencer (bdrs_seq).
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef BLOCK_DECOMPOSED_RANGE_SUM_CORE_DEFINES_SVH
`define BLOCK_DECOMPOSED_RANGE_SUM_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BDRS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BDRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/bdrs_pkg.sv -----
// Types, sizes and codes for the block-decomposed range sum core.
// No dependencies; used by bdrs_seq and the top level.
package bdrs_pkg;

  localparam int IDX_W        = 10;
  localparam int MAX_ELEMENTS = 1 << IDX_W;
  localparam int BLOCK_SIZE   = 32;
  localparam int BLK_W        = $clog2(BLOCK_SIZE);
  localparam int GROUPS       = MAX_ELEMENTS / BLOCK_SIZE;
  localparam int GRP_W        = IDX_W - BLK_W;
  localparam int CNT_W        = IDX_W + 1;
  localparam int VAL_W        = 32;
  localparam int BSUM_W       = VAL_W + BLK_W;
  localparam int SUM_W        = 42;

  localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(MAX_ELEMENTS);

  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPD_WR,
    ST_QRUN
  } state_e;

  typedef struct packed {
    logic                    command;
    logic [IDX_W-1:0]        first_index;
    logic [IDX_W-1:0]        last_index;
    logic signed [VAL_W-1:0] new_value;
  } cmd_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] range_sum;
    logic                    range_error;
  } rsp_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [VAL_W-1:0] wdata;
    logic [IDX_W-1:0] raddr;
  } elem_req_t;

  typedef struct packed {
    logic              we;
    logic [GRP_W-1:0]  waddr;
    logic [BSUM_W-1:0] wdata;
    logic [GRP_W-1:0]  raddr;
  } blk_req_t;

endpackage

// ----- hw/rtl/bdrs_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bdrs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- hw/rtl/bdrs_seq.sv -----
// Sequencer of the range sum core: clearing pass, update read-modify-write,
// query walk and result register. Depends on bdrs_pkg and the defines header.
`include "block_decomposed_range_sum_core_defines.svh"

module bdrs_seq (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  bdrs_pkg::cmd_t               cmd_i,
  input  logic [bdrs_pkg::CNT_W-1:0]   count_i,
  output bdrs_pkg::elem_req_t          elem_req_o,
  output bdrs_pkg::blk_req_t           blk_req_o,
  input  logic [bdrs_pkg::VAL_W-1:0]   elem_rdata_i,
  input  logic [bdrs_pkg::BSUM_W-1:0]  blk_rdata_i,
  output logic                         strobe_o,
  output bdrs_pkg::rsp_t               rsp_o
);

  localparam int IDX_W  = bdrs_pkg::IDX_W;
  localparam int BLK_W  = bdrs_pkg::BLK_W;
  localparam int VAL_W  = bdrs_pkg::VAL_W;
  localparam int BSUM_W = bdrs_pkg::BSUM_W;
  localparam int SUM_W  = bdrs_pkg::SUM_W;

  bdrs_pkg::state_e state_q, state_d;

  logic [IDX_W-1:0]        clr_q, clr_d;
  logic [IDX_W:0]          cursor_q, cursor_d;
  logic [IDX_W-1:0]        hi_q, hi_d;
  logic [IDX_W-1:0]        upd_idx_q, upd_idx_d;
  logic [VAL_W-1:0]        upd_val_q, upd_val_d;
  logic                    pend_q, pend_d;
  logic                    pend_blk_q, pend_blk_d;
  logic signed [SUM_W-1:0] acc_q, acc_d;
  logic                    out_valid_q, out_valid_d;
  bdrs_pkg::rsp_t          rsp_q, rsp_d;

  logic lo_ok, hi_ok;

  assign lo_ok = {1'b0, cmd_i.first_index} < count_i;
  assign hi_ok = {1'b0, cmd_i.last_index} < count_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bdrs_pkg::ST_CLEAR;
      clr_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cursor_q   <= cursor_d;
    hi_q       <= hi_d;
    upd_idx_q  <= upd_idx_d;
    upd_val_q  <= upd_val_d;
    pend_blk_q <= pend_blk_d;
    acc_q      <= acc_d;
    rsp_q      <= rsp_d;
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    cursor_d    = cursor_q;
    hi_d        = hi_q;
    upd_idx_d   = upd_idx_q;
    upd_val_d   = upd_val_q;
    pend_d      = 1'b0;
    pend_blk_d  = pend_blk_q;
    acc_d       = acc_q;
    out_valid_d = 1'b0;
    rsp_d       = rsp_q;
    busy_o      = 1'b1;
    elem_req_o  = '0;
    blk_req_o   = '0;

    case (state_q)
      bdrs_pkg::ST_CLEAR: begin
        // Zero one element per cycle; the first rows also zero the block sums.
        elem_req_o.we    = 1'b1;
        elem_req_o.waddr = clr_q;
        blk_req_o.we     = (clr_q[IDX_W-1:bdrs_pkg::GRP_W] == '0);
        blk_req_o.waddr  = clr_q[bdrs_pkg::GRP_W-1:0];
        clr_d            = clr_q + 1'b1;
        if (clr_q == IDX_W'(bdrs_pkg::MAX_ELEMENTS - 1)) begin
          state_d = bdrs_pkg::ST_IDLE;
        end
      end

      bdrs_pkg::ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          if (cmd_i.command == bdrs_pkg::CMD_UPDATE) begin
            // Drop out-of-range updates silently.
            if (lo_ok) begin
              elem_req_o.raddr = cmd_i.first_index;
              blk_req_o.raddr  = cmd_i.first_index[IDX_W-1:BLK_W];
              upd_idx_d        = cmd_i.first_index;
              upd_val_d        = cmd_i.new_value;
              state_d          = bdrs_pkg::ST_UPD_WR;
            end
          end else if (!lo_ok || !hi_ok) begin
            rsp_d.range_sum   = '0;
            rsp_d.range_error = 1'b1;
            out_valid_d       = 1'b1;
          end else if (cmd_i.first_index > cmd_i.last_index) begin
            rsp_d.range_sum   = '0;
            rsp_d.range_error = 1'b0;
            out_valid_d       = 1'b1;
          end else begin
            cursor_d = {1'b0, cmd_i.first_index};
            hi_d     = cmd_i.last_index;
            acc_d    = '0;
            state_d  = bdrs_pkg::ST_QRUN;
          end
        end
      end

      bdrs_pkg::ST_UPD_WR: begin
        // Write the new element and correct its block sum by the difference.
        elem_req_o.we    = 1'b1;
        elem_req_o.waddr = upd_idx_q;
        elem_req_o.wdata = upd_val_q;
        blk_req_o.we     = 1'b1;
        blk_req_o.waddr  = upd_idx_q[IDX_W-1:BLK_W];
        blk_req_o.wdata  = blk_rdata_i
                         + {{(BSUM_W-VAL_W){upd_val_q[VAL_W-1]}}, upd_val_q}
                         - {{(BSUM_W-VAL_W){elem_rdata_i[VAL_W-1]}}, elem_rdata_i};
        state_d          = bdrs_pkg::ST_IDLE;
      end

      bdrs_pkg::ST_QRUN: begin
        // Accumulate the word read in the previous cycle.
        if (pend_q) begin
          if (pend_blk_q) begin
            acc_d = acc_q + {{(SUM_W-BSUM_W){blk_rdata_i[BSUM_W-1]}}, blk_rdata_i};
          end else begin
            acc_d = acc_q + {{(SUM_W-VAL_W){elem_rdata_i[VAL_W-1]}}, elem_rdata_i};
          end
        end
        if (cursor_q <= {1'b0, hi_q}) begin
          pend_d = 1'b1;
          // Take a whole block when aligned and fully inside the range.
          if ((cursor_q[BLK_W-1:0] == '0) &&
              (cursor_q + (IDX_W+1)'(bdrs_pkg::BLOCK_SIZE - 1) <= {1'b0, hi_q})) begin
            blk_req_o.raddr = cursor_q[IDX_W-1:BLK_W];
            pend_blk_d      = 1'b1;
            cursor_d        = cursor_q + (IDX_W+1)'(bdrs_pkg::BLOCK_SIZE);
          end else begin
            elem_req_o.raddr = cursor_q[IDX_W-1:0];
            pend_blk_d       = 1'b0;
            cursor_d         = cursor_q + 1'b1;
          end
        end else if (!pend_q) begin
          rsp_d.range_sum   = acc_q;
          rsp_d.range_error = 1'b0;
          out_valid_d       = 1'b1;
          state_d           = bdrs_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = bdrs_pkg::ST_IDLE;
      end
    endcase
  end

  assign strobe_o = out_valid_q;
  assign rsp_o    = rsp_q;

  `BDRS_ASSERT_NEXT(a_update_no_result,
    start_i && !busy_o && cmd_i.command == bdrs_pkg::CMD_UPDATE, !strobe_o,
    "update request produced a result")
  `BDRS_ASSERT_NOW(a_write_owner, elem_req_o.we || blk_req_o.we,
    state_q == bdrs_pkg::ST_CLEAR || state_q == bdrs_pkg::ST_UPD_WR,
    "memory write outside clearing pass or update")
  `BDRS_ASSERT_NOW(a_pend_in_walk, pend_q, state_q == bdrs_pkg::ST_QRUN,
    "pending read outside query walk")
  `BDRS_ASSERT_NOW(a_cursor_bound, state_q == bdrs_pkg::ST_QRUN,
    cursor_q <= ({1'b0, hi_q} + (IDX_W+1)'(1)),
    "query cursor ran past the range end")

endmodule

// ----- hw/rtl/block_decomposed_range_sum_core.sv -----
// Block-decomposed range sum core: an update reads on accept and writes in ST_UPD_WR
// (busy high). A query walks head elements, whole block sums and tail elements, one
// memory read per cycle, at most 92 reads; strobe and next accept come as the walk
// ends. Error and empty-range queries strobe in the cycle after accept. The receiver
// cannot stall. After reset a clearing pass zeroes both memories with busy high;
// configuration writes are taken during it. Depends on bdrs_pkg, bdrs_seq, bdrs_ram.
module block_decomposed_range_sum_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Request channel: accepted when start is high and busy is low.
  input  logic                        start,
  output logic                        busy,
  input  bdrs_pkg::cmd_t              cmd_i,
  // Element count register, written directly.
  input  logic                        cfg_we_i,
  input  logic [bdrs_pkg::CNT_W-1:0]  cfg_wdata_i,
  // Result, valid for exactly one cycle while strobe_o is high.
  output logic                        strobe_o,
  output bdrs_pkg::rsp_t              rsp_o
);

  localparam int CNT_W = bdrs_pkg::CNT_W;

  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] eff_count;

  bdrs_pkg::elem_req_t             elem_req;
  bdrs_pkg::blk_req_t              blk_req;
  logic [bdrs_pkg::VAL_W-1:0]      elem_rdata;
  logic [bdrs_pkg::BSUM_W-1:0]     blk_rdata;

  // Hold the element count; load on every write, no handshake.
  assign count_d = cfg_we_i ? cfg_wdata_i : count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= bdrs_pkg::COUNT_RESET;
    end else begin
      count_q <= count_d;
    end
  end

  // Clamp a count above the array depth to the depth.
  assign eff_count = (count_q > CNT_W'(bdrs_pkg::MAX_ELEMENTS)) ?
                     CNT_W'(bdrs_pkg::MAX_ELEMENTS) : count_q;

  // Sequencer: owns both memory ports and the result register.
  bdrs_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_o       (busy),
    .cmd_i        (cmd_i),
    .count_i      (eff_count),
    .elem_req_o   (elem_req),
    .blk_req_o    (blk_req),
    .elem_rdata_i (elem_rdata),
    .blk_rdata_i  (blk_rdata),
    .strobe_o     (strobe_o),
    .rsp_o        (rsp_o)
  );

  // Element array: one 32-bit word per element.
  bdrs_ram #(
    .WIDTH (bdrs_pkg::VAL_W),
    .DEPTH (bdrs_pkg::MAX_ELEMENTS)
  ) u_elem_ram (
    .clk_i   (clk_i),
    .we_i    (elem_req.we),
    .waddr_i (elem_req.waddr),
    .wdata_i (elem_req.wdata),
    .raddr_i (elem_req.raddr),
    .rdata_o (elem_rdata)
  );

  // Block sum array: one running sum per group of elements.
  bdrs_ram #(
    .WIDTH (bdrs_pkg::BSUM_W),
    .DEPTH (bdrs_pkg::GROUPS)
  ) u_blk_ram (
    .clk_i   (clk_i),
    .we_i    (blk_req.we),
    .waddr_i (blk_req.waddr),
    .wdata_i (blk_req.wdata),
    .raddr_i (blk_req.raddr),
    .rdata_o (blk_rdata)
  );

endmodule
